FILE: rtl/core/dms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dms_pkg;

    // buffer depth and element width
    localparam int DEPTH_DEFAULT = 1024;
    localparam int DATA_W        = 32;

    // s_axis_tuser codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/dms_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/descending_merge_sort_core.sv
// descending merge sort core
//
// input stream: s_axis_tuser selects the beat kind (0 load, 1 read), s_axis_tdata
// carries the signed element on loads, s_axis_tlast on a load marks the final
// element of the batch and starts the sort. loads past DEPTH are dropped and
// set the overflow flag; a load after a finished sort starts a new batch.
// output stream: one beat per read, none per load. tdata is the next element in
// descending order (ties keep load order), tlast marks the final element,
// tuser[0] flags a read that found nothing left, tuser[1] the overflow flag.
// an accepted read waits in ST_READ until the output register is free, then
// loads its beat there. the sort runs bottom-up over two ping-pong RAMs with
// one compare unit and one RAM read port: each of the ceil(log2(n)) passes
// reads the two heads of every merged block, then writes one element per merge
// step with a refill read between steps; s_axis_tready is low meanwhile.
// reset (aresetn low, synchronous) empties the store and drops any pending beat;
// RAM contents are not cleared. a stalled m_axis holds its beat in the output
// register; loads may still be taken, a read waits until the beat leaves.
`timescale 1ns / 1ps
`default_nettype none

module descending_merge_sort_core #(
    parameter int DEPTH = dms_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [dms_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  wire logic                       s_axis_tlast,   // last
    input  wire logic                       s_axis_tuser,   // [0] func

    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic      [dms_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic                            m_axis_tlast,   // final_res
    output logic      [1:0]                 m_axis_tuser    // [0] empty_res, [1] overflow
);

    localparam int DW = dms_pkg::DATA_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PASS,
        ST_BLOCK,
        ST_HEAD_L,
        ST_HEAD_R,
        ST_MERGE,
        ST_REFILL
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rp_reg, rp_next;
    logic            ready_reg, ready_next;
    logic            ovf_reg, ovf_next;
    logic            sel_reg, sel_next;
    logic [WW-1:0]   width_reg, width_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   mid_reg, mid_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [DW-1:0]   head_l_reg, head_l_next;
    logic [DW-1:0]   head_r_reg, head_r_next;
    logic            took_l_reg, took_l_next;
    logic            m_valid_reg, m_valid_next;
    logic [DW-1:0]   m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;
    logic            m_empty_reg, m_empty_next;
    logic            m_ovf_reg, m_ovf_next;

    logic            we_a, we_b;
    logic [AW-1:0]   waddr, raddr;
    logic [DW-1:0]   wdata;
    logic [DW-1:0]   rdata_a, rdata_b, rdata_src;

    logic            fire_in, out_free, take_l;
    logic [CW-1:0]   load_base, load_inc, i_inc, j_inc, k_inc, rp_inc;
    logic [SW-1:0]   sum_lw, sum_mw;
    logic [CW-1:0]   mid_calc, hi_calc;

    dms_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
        .clk   (aclk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    dms_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
        .clk   (aclk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign fire_in       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign rdata_src     = sel_reg ? rdata_b : rdata_a;

    // a finished batch is discarded by the next load
    assign load_base = ready_reg ? '0 : count_reg;
    assign load_inc  = load_base + CW'(1);
    assign i_inc     = i_reg + CW'(1);
    assign j_inc     = j_reg + CW'(1);
    assign k_inc     = k_reg + CW'(1);
    assign rp_inc    = rp_reg + CW'(1);

    // block bounds, clipped to the element count
    assign sum_lw   = {2'b00, lo_reg} + {1'b0, width_reg};
    assign mid_calc = (sum_lw < {2'b00, count_reg}) ? sum_lw[CW-1:0] : count_reg;
    assign sum_mw   = {2'b00, mid_calc} + {1'b0, width_reg};
    assign hi_calc  = (sum_mw < {2'b00, count_reg}) ? sum_mw[CW-1:0] : count_reg;

    // shared compare: left run wins ties, exhausted runs never win
    assign take_l = (j_reg >= hi_reg)
                 || ((i_reg < mid_reg) && ($signed(head_l_reg) >= $signed(head_r_reg)));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rp_next      = rp_reg;
        ready_next   = ready_reg;
        ovf_next     = ovf_reg;
        sel_next     = sel_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        head_l_next  = head_l_reg;
        head_r_next  = head_r_reg;
        took_l_next  = took_l_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_empty_next = m_empty_reg;
        m_ovf_next   = m_ovf_reg;

        we_a  = 1'b0;
        we_b  = 1'b0;
        waddr = k_reg[AW-1:0];
        wdata = take_l ? head_l_reg : head_r_reg;
        raddr = rp_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (fire_in) begin
                    if (s_axis_tuser == dms_pkg::FUNC_LOAD) begin
                        if (ready_reg) begin
                            rp_next    = '0;
                            ready_next = 1'b0;
                        end
                        ovf_next = ready_reg ? 1'b0 : ovf_reg;
                        if (load_base < CW'(DEPTH)) begin
                            we_a       = 1'b1;
                            waddr      = load_base[AW-1:0];
                            wdata      = s_axis_tdata;
                            count_next = load_inc;
                        end else begin
                            count_next = load_base;
                            ovf_next   = 1'b1;
                        end
                        if (s_axis_tlast) begin
                            rp_next    = '0;
                            sel_next   = 1'b0;
                            width_next = WW'(1);
                            state_next = ST_PASS;
                        end
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ovf_next   = ovf_reg;
                    if (ready_reg && (rp_reg < count_reg)) begin
                        m_data_next  = rdata_src;
                        m_last_next  = (rp_inc == count_reg);
                        m_empty_next = 1'b0;
                        rp_next      = rp_inc;
                    end else begin
                        m_data_next  = '0;
                        m_last_next  = 1'b0;
                        m_empty_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_PASS: begin
                if (width_reg < {1'b0, count_reg}) begin
                    lo_next    = '0;
                    state_next = ST_BLOCK;
                end else begin
                    // result sits in the RAM named by sel_reg
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_BLOCK: begin
                if (lo_reg >= count_reg) begin
                    width_next = width_reg << 1;
                    sel_next   = !sel_reg;
                    state_next = ST_PASS;
                end else begin
                    mid_next   = mid_calc;
                    hi_next    = hi_calc;
                    i_next     = lo_reg;
                    j_next     = mid_calc;
                    k_next     = lo_reg;
                    raddr      = lo_reg[AW-1:0];
                    state_next = ST_HEAD_L;
                end
            end

            ST_HEAD_L: begin
                head_l_next = rdata_src;
                raddr       = j_reg[AW-1:0];
                state_next  = ST_HEAD_R;
            end

            ST_HEAD_R: begin
                head_r_next = rdata_src;
                state_next  = ST_MERGE;
            end

            ST_MERGE: begin
                we_a        = sel_reg;
                we_b        = !sel_reg;
                k_next      = k_inc;
                took_l_next = take_l;
                if (take_l) begin
                    i_next = i_inc;
                    raddr  = i_inc[AW-1:0];
                end else begin
                    j_next = j_inc;
                    raddr  = j_inc[AW-1:0];
                end
                if (k_inc == hi_reg) begin
                    lo_next    = hi_reg;
                    state_next = ST_BLOCK;
                end else begin
                    state_next = ST_REFILL;
                end
            end

            ST_REFILL: begin
                if (took_l_reg) begin
                    head_l_next = rdata_src;
                end else begin
                    head_r_next = rdata_src;
                end
                state_next = ST_MERGE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rp_reg      <= '0;
            ready_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rp_reg      <= rp_next;
            ready_reg   <= ready_next;
            ovf_reg     <= ovf_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
        width_reg   <= width_next;
        lo_reg      <= lo_next;
        mid_reg     <= mid_next;
        hi_reg      <= hi_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        head_l_reg  <= head_l_next;
        head_r_reg  <= head_r_next;
        took_l_reg  <= took_l_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_empty_reg <= m_empty_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = {m_ovf_reg, m_empty_reg};

endmodule

`default_nettype wire

FILE: rtl/core/dms_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dms_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic                       s_axis_tlast,
    input wire logic                       s_axis_tuser,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [dms_pkg::DATA_W-1:0] m_axis_tdata,
    input wire logic                       m_axis_tlast,
    input wire logic [1:0]                 m_axis_tuser
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    // an empty read carries no element
    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("empty read with data or final flag");

    // the final load starts the sort, which blocks the input
    a_sort_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == dms_pkg::FUNC_LOAD) && s_axis_tlast
            |=> !s_axis_tready)
        else $error("input ready right after the final load");

    // a read is served before the next beat is taken
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == dms_pkg::FUNC_READ)
            |=> !s_axis_tready)
        else $error("input ready right after a read");

endmodule

bind descending_merge_sort_core dms_checker u_dms_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: dv/tb_descending_merge_sort_core.sv
`timescale 1ns / 1ps

module tb_descending_merge_sort_core;

    localparam int DW          = dms_pkg::DATA_W;
    localparam int NUM         = dms_pkg::DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 100000;
    localparam int HOLD_CYCLES = 3000;
    localparam int FULL_READS  = 32;
    localparam int RANDOM_ITEMS = 100;

    typedef struct {
        logic [DW-1:0] value;
        logic          final_flag;
        logic          empty_flag;
        logic          ovf;
    } sorted_beat_t;

    class sort_scoreboard;
        logic signed [DW-1:0] bank [2][NUM];
        int           count;
        int           rd_ptr;
        bit           sorted;
        bit           ovf;
        sorted_beat_t expected_q[$];
        int           errors;
        int           loads;
        int           reads;
        int           batches;
        int           checked;
        int           dropped;
        int           biggest;

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        // bottom-up stable merge, descending, left run wins ties
        function void sort_held();
            int w, lo, mid, hi, i, j, k, s;
            s = 0;
            for (w = 1; w < count; w = w * 2) begin
                for (lo = 0; lo < count; lo = lo + 2 * w) begin
                    mid = (lo + w < count) ? lo + w : count;
                    hi  = (mid + w < count) ? mid + w : count;
                    i = lo;
                    j = mid;
                    for (k = lo; k < hi; k++) begin
                        if (j >= hi || (i < mid && bank[s][i] >= bank[s][j])) begin
                            bank[1-s][k] = bank[s][i];
                            i++;
                        end else begin
                            bank[1-s][k] = bank[s][j];
                            j++;
                        end
                    end
                end
                s = 1 - s;
            end
            if (s != 0) begin
                for (k = 0; k < count; k++) bank[0][k] = bank[1][k];
            end
        endfunction

        function void note_input(logic func, logic [DW-1:0] value, logic last);
            sorted_beat_t b;
            if (func == dms_pkg::FUNC_LOAD) begin
                loads++;
                // a load after a finished sort opens a new batch
                if (sorted) begin
                    count  = 0;
                    rd_ptr = 0;
                    sorted = 0;
                    ovf    = 0;
                end
                if (count < NUM) begin
                    bank[0][count] = value;
                    count++;
                end else begin
                    ovf = 1;
                    dropped++;
                end
                if (last) begin
                    sort_held();
                    rd_ptr = 0;
                    sorted = 1;
                    batches++;
                    if (count > biggest) biggest = count;
                end
            end else begin
                reads++;
                b.ovf = ovf;
                if (sorted && rd_ptr < count) begin
                    b.value      = bank[0][rd_ptr];
                    b.final_flag = (rd_ptr + 1 == count);
                    b.empty_flag = 1'b0;
                    rd_ptr++;
                end else begin
                    b.value      = '0;
                    b.final_flag = 1'b0;
                    b.empty_flag = 1'b1;
                end
                expected_q = {expected_q, b};
            end
        endfunction

        task check_result(logic [DW-1:0] value, logic final_flag, logic [1:0] flags);
            sorted_beat_t b;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat %h with nothing expected", value));
                return;
            end
            b = expected_q.pop_front();
            checked++;
            if (value !== b.value)
                report($sformatf("beat %0d value %h, want %h", checked, value, b.value));
            if (final_flag !== b.final_flag)
                report($sformatf("beat %0d tlast %b, want %b", checked, final_flag,
                                 b.final_flag));
            if (flags[0] !== b.empty_flag)
                report($sformatf("beat %0d empty %b, want %b", checked, flags[0],
                                 b.empty_flag));
            if (flags[1] !== b.ovf)
                report($sformatf("beat %0d overflow %b, want %b", checked, flags[1], b.ovf));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic          aclk;
    logic          aresetn       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata  = '0;
    logic          s_axis_tlast  = 1'b0;
    logic          s_axis_tuser  = dms_pkg::FUNC_LOAD;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;
    logic          m_axis_tlast;
    logic [1:0]    m_axis_tuser;

    sort_scoreboard sb = new();
    bit             quiet    = 1'b0;
    bit             hold_req = 1'b0;
    int             items_sent;
    int             idle_cycles;

    descending_merge_sort_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] value
        .s_axis_tlast  (s_axis_tlast),   // last
        .s_axis_tuser  (s_axis_tuser),   // [0] func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] sorted_value
        .m_axis_tlast  (m_axis_tlast),   // final_res
        .m_axis_tuser  (m_axis_tuser)    // [0] empty_res, [1] overflow
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stalls, one long hold-off while reads pile up
    initial begin
        int held;
        held = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && held < HOLD_CYCLES) begin
                m_axis_tready <= 1'b0;
                held++;
            end else if (quiet) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 11);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_descending_merge_sort_core failed");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic func, input logic [DW-1:0] value, input logic last);
        while (!quiet && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_input(func, value, last);
        items_sent++;
    endtask

    task automatic read_beats(input int n);
        for (int r = 0; r < n; r++)
            send_beat(dms_pkg::FUNC_READ, DW'($urandom), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [DW-1:0] pick_value(input int mode);
        int v;
        case (mode)
            0: return DW'($urandom);
            1: begin
                // narrow pool so ties are common
                v = int'($urandom_range(0, 7));
                v = v - 4;
                return DW'(v);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: return {1'b0, {(DW-1){1'b1}}};
                    1: return {1'b1, {(DW-1){1'b0}}};
                    2: return '0;
                    3: return '1;
                    default: return DW'(1);
                endcase
            end
        endcase
    endfunction

    initial begin
        int n, reads, mode, start;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // read before any sort, carrying tlast
        send_beat(dms_pkg::FUNC_READ, '1, 1'b1);
        // extremes, duplicates of the most negative value
        send_beat(dms_pkg::FUNC_LOAD, {1'b0, {(DW-1){1'b1}}}, 1'b0);
        send_beat(dms_pkg::FUNC_LOAD, {1'b1, {(DW-1){1'b0}}}, 1'b0);
        send_beat(dms_pkg::FUNC_LOAD, '0, 1'b0);
        send_beat(dms_pkg::FUNC_LOAD, '1, 1'b0);
        send_beat(dms_pkg::FUNC_LOAD, {1'b1, {(DW-1){1'b0}}}, 1'b0);
        send_beat(dms_pkg::FUNC_LOAD, DW'(1), 1'b1);
        read_beats(8);
        // single element batch
        send_beat(dms_pkg::FUNC_LOAD, 32'h5a5a_a5a5, 1'b1);
        read_beats(2);
        // new batch not yet sorted reads empty, last on reads does nothing
        send_beat(dms_pkg::FUNC_LOAD, 32'h0000_0003, 1'b0);
        send_beat(dms_pkg::FUNC_READ, '0, 1'b1);
        send_beat(dms_pkg::FUNC_LOAD, 32'hffff_fffd, 1'b1);
        read_beats(1);
        // load after partial read opens a new batch
        send_beat(dms_pkg::FUNC_LOAD, 32'h0000_0007, 1'b1);
        read_beats(2);

        // full store plus dropped loads, last rides on a dropped one, no idling here
        quiet = 1'b1;
        for (int e = 0; e < NUM + 3; e++)
            send_beat(dms_pkg::FUNC_LOAD, pick_value(int'($urandom_range(0, 2))),
                      e == NUM + 2);
        quiet = 1'b0;
        // first read waits out the sort, then the receiver holds off while reads pile up
        read_beats(1);
        hold_req = 1'b1;
        read_beats(FULL_READS - 1);

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 20);
            mode = $urandom_range(0, 3);
            for (int e = 0; e < n; e++) begin
                if ($urandom_range(0, 19) == 0) read_beats(1);
                send_beat(dms_pkg::FUNC_LOAD,
                          pick_value(mode == 3 ? int'($urandom_range(0, 2)) : mode),
                          e == n - 1);
            end
            reads = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n)
                                                : n + $urandom_range(0, 2);
            read_beats(reads);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (sb.pending() != 0) sb.report("expected beats left over");
        $display("ran %0d loads and %0d reads over %0d sorted batches, %0d beats checked",
                 sb.loads, sb.reads, sb.batches, sb.checked);
        $display("largest batch %0d elements, %0d loads dropped on a full store",
                 sb.biggest, sb.dropped);
        if (sb.errors == 0) begin
            $display("tb_descending_merge_sort_core passed");
        end else begin
            $display("tb_descending_merge_sort_core failed");
        end
        $finish;
    end

endmodule

FILE: descending_merge_sort_core.f
rtl/core/dms_pkg.sv
rtl/core/dms_ram.sv
rtl/core/descending_merge_sort_core.sv
rtl/core/dms_checker.sv
dv/tb_descending_merge_sort_core.sv
